// ===== hw/rtl/axtx_pkg.sv =====
`default_nettype none

package axtx_pkg;

    // transmit phase, also reported in each result
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_OPEN  = 3'd1,
        PH_DATA  = 3'd2,
        PH_FCS   = 3'd3,
        PH_CLOSE = 3'd4
    } phase_t;

    // input item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_OPENING_FLAGS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSING_FLAGS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH  = 2'd2;

    // configuration reset values
    localparam logic [9:0] OPENING_FLAGS_RST = 10'd101;
    localparam logic [7:0] CLOSING_FLAGS_RST = 8'd11;
    localparam logic [6:0] FRAME_LENGTH_RST  = 7'd64;

    // framing constants
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [2:0]  STUFF_RUN = 3'd5;
    localparam logic [9:0]  FCS_BYTES = 10'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] byte_index;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic       line_level;
        logic       tx_enable;
        logic       frame_done;
        logic [2:0] phase;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_write_t;

endpackage

`default_nettype wire

// ===== hw/rtl/axtx_item_if.sv =====
`default_nettype none

interface axtx_item_if;
    logic            valid;
    logic            ready;
    axtx_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/axtx_result_if.sv =====
`default_nettype none

interface axtx_result_if;
    logic              valid;
    logic              ready;
    axtx_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/axtx_cfg_if.sv =====
`default_nettype none

interface axtx_cfg_if;
    logic                 valid;
    logic                 ready;
    axtx_pkg::cfg_write_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/axtx_frame_buf.sv =====
`default_nettype none

// frame byte store, one write and one registered read per cycle,
// a write to the address being read is forwarded
module axtx_frame_buf #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/axtx_out_queue.sv =====
`default_nettype none

// two-slot result queue, full flag is decoded from the count register
module axtx_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire axtx_pkg::result_t push_data,
    output logic                   full,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output axtx_pkg::result_t      pop_data
);

    axtx_pkg::result_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ax25_hdlc_nrzi_transmitter.sv =====
// ax.25 / hdlc frame transmitter with nrzi line coding and crc-16 fcs
// items channel: load (write one byte into the frame buffer), start (restart
//   the frame, line high, crc preset) and tick (one bit clock edge)
// results channel: one transfer per tick with line level, transmit enable,
//   frame done and the phase of the bit sent; loads and starts give none
// cfg channel: register writes (opening flags, closing flags, frame length),
//   always ready; the user writes only while no item or result is in flight,
//   unenforced by the block; a mid-frame write acts at the next phase-end check
// output: a tick's result is registered into the result queue and offered from there
// throughput: one item per cycle while a result slot is free, each item goes
//   through one layer of logic (bit select, crc step, stuff and nrzi update)
//   between the state registers and the result queue; frame bytes come from a
//   registered buffer read that is prefetched for the next byte position
// stall: results wait in a two-slot queue; items keeps accepting while one
//   result waits and holds off only when both slots are full
// reset: idle phase, line level high, crc preset, register defaults
//   (101 opening flags, 11 closing flags, 64 frame bytes); the frame buffer
//   holds no defined contents until written
`default_nettype none

module ax25_hdlc_nrzi_transmitter #(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    axtx_item_if.sink   items,
    axtx_result_if.source results,
    axtx_cfg_if.sink    cfg
);

    localparam int unsigned ADDR_W    = $clog2(BUFFER_DEPTH);
    localparam logic [9:0]  DEPTH_LIM = 10'(BUFFER_DEPTH);

    // configuration registers
    logic [9:0] opening_reg;
    logic [7:0] closing_reg;
    logic [6:0] length_reg;

    // transmit state
    axtx_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  bit_pos_reg, bit_pos_next;
    logic [9:0]  count_reg, count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  ones_reg, ones_next;
    logic        stuff_reg, stuff_next;
    logic        level_reg, level_next;

    // per-item working signals
    logic              in_fire;
    logic              cfg_fire;
    logic              q_full;
    logic              res_push;
    axtx_pkg::result_t res_data;
    logic              buf_wr;
    logic              idx_ok;
    logic [ADDR_W-1:0] buf_wr_addr;
    logic [ADDR_W-1:0] buf_rd_addr;
    logic [7:0]        buf_rd_data;
    logic [7:0]        cur_byte;
    logic [15:0]       fcs;
    logic              tx_bit;
    logic [2:0]        ones_inc;
    logic [9:0]        data_lim;
    logic [9:0]        raw_lim;
    logic [9:0]        lim;
    logic              frame_end;

    assign in_fire  = items.valid && items.ready;
    assign cfg_fire = cfg.valid && cfg.ready;

    // accept while at least one result slot is free
    assign items.ready = ~q_full;
    assign cfg.ready   = 1'b1;

    assign idx_ok      = (32'(items.payload.byte_index) < 32'(BUFFER_DEPTH));
    assign buf_wr_addr = ADDR_W'(items.payload.byte_index);
    // prefetch the byte at the position the next tick will load from
    assign buf_rd_addr = count_next[ADDR_W-1:0];

    assign fcs      = crc_reg ^ axtx_pkg::CRC_INIT;
    assign data_lim = ({3'b000, length_reg} > DEPTH_LIM) ? DEPTH_LIM : {3'b000, length_reg};

    // byte count that ends the current phase, a zero count acts as one
    always_comb
    begin
        case (phase_reg)
            axtx_pkg::PH_OPEN: raw_lim = opening_reg;
            axtx_pkg::PH_DATA: raw_lim = data_lim;
            axtx_pkg::PH_FCS:  raw_lim = axtx_pkg::FCS_BYTES;
            default:           raw_lim = {2'b00, closing_reg};
        endcase
        lim = (raw_lim == 10'd0) ? 10'd1 : raw_lim;
    end

    // byte being shifted out: the shift register mid-byte, a new byte when one begins
    always_comb
    begin
        if (bit_pos_reg != 3'd0)
        begin
            cur_byte = shift_reg;
        end
        else
        begin
            case (phase_reg)
                axtx_pkg::PH_DATA: cur_byte = buf_rd_data;
                axtx_pkg::PH_FCS:  cur_byte = (count_reg == 10'd0) ? fcs[7:0] : fcs[15:8];
                default:           cur_byte = axtx_pkg::FLAG_BYTE;
            endcase
        end
    end

    assign tx_bit   = cur_byte[0];
    assign ones_inc = ones_reg + 3'd1;

    // next state and result for the item at the input
    always_comb
    begin
        phase_next   = phase_reg;
        bit_pos_next = bit_pos_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        crc_next     = crc_reg;
        ones_next    = ones_reg;
        stuff_next   = stuff_reg;
        level_next   = level_reg;
        res_push     = 1'b0;
        res_data     = '0;
        buf_wr       = 1'b0;
        frame_end    = 1'b0;

        if (in_fire)
        begin
            case (items.payload.kind)
                axtx_pkg::KIND_LOAD:
                begin
                    buf_wr = idx_ok;
                end
                axtx_pkg::KIND_START:
                begin
                    phase_next   = axtx_pkg::PH_OPEN;
                    bit_pos_next = 3'd0;
                    count_next   = 10'd0;
                    shift_next   = 8'd0;
                    crc_next     = axtx_pkg::CRC_INIT;
                    ones_next    = 3'd0;
                    stuff_next   = 1'b0;
                    level_next   = 1'b1;
                end
                axtx_pkg::KIND_TICK:
                begin
                    res_push = 1'b1;
                    if (phase_reg == axtx_pkg::PH_IDLE)
                    begin
                        res_data.line_level = level_reg;
                        res_data.phase      = axtx_pkg::PH_IDLE;
                    end
                    else
                    begin
                        if (stuff_reg)
                        begin
                            // stuffed zero, not part of the crc
                            level_next = ~level_reg;
                            stuff_next = 1'b0;
                            ones_next  = 3'd0;
                        end
                        else
                        begin
                            shift_next = {1'b0, cur_byte[7:1]};
                            if (phase_reg == axtx_pkg::PH_DATA)
                            begin
                                crc_next = {1'b0, crc_reg[15:1]}
                                         ^ ((crc_reg[0] ^ tx_bit) ? axtx_pkg::CRC_POLY : 16'h0000);
                            end
                            if (!tx_bit)
                            begin
                                level_next = ~level_reg;
                                ones_next  = 3'd0;
                            end
                            else if ((phase_reg == axtx_pkg::PH_DATA) ||
                                     (phase_reg == axtx_pkg::PH_FCS))
                            begin
                                ones_next  = ones_inc;
                                stuff_next = (ones_inc >= axtx_pkg::STUFF_RUN);
                            end
                            else
                            begin
                                ones_next = 3'd0;
                            end
                            bit_pos_next = bit_pos_reg + 3'd1;
                            if (bit_pos_reg == 3'd7)
                            begin
                                count_next = count_reg + 10'd1;
                            end
                        end

                        // byte boundary with the phase's count reached
                        if ((bit_pos_next == 3'd0) && !stuff_next && (count_next >= lim))
                        begin
                            count_next = 10'd0;
                            case (phase_reg)
                                axtx_pkg::PH_OPEN: phase_next = axtx_pkg::PH_DATA;
                                axtx_pkg::PH_DATA: phase_next = axtx_pkg::PH_FCS;
                                axtx_pkg::PH_FCS:  phase_next = axtx_pkg::PH_CLOSE;
                                default:
                                begin
                                    phase_next = axtx_pkg::PH_IDLE;
                                    frame_end  = 1'b1;
                                end
                            endcase
                        end

                        res_data.line_level = level_next;
                        res_data.tx_enable  = 1'b1;
                        res_data.frame_done = frame_end;
                        res_data.phase      = phase_reg;
                    end
                end
                default:
                begin
                    // unused kind code, dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= axtx_pkg::PH_IDLE;
            bit_pos_reg <= 3'd0;
            count_reg   <= 10'd0;
            shift_reg   <= 8'd0;
            crc_reg     <= axtx_pkg::CRC_INIT;
            ones_reg    <= 3'd0;
            stuff_reg   <= 1'b0;
            level_reg   <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            bit_pos_reg <= bit_pos_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            crc_reg     <= crc_next;
            ones_reg    <= ones_next;
            stuff_reg   <= stuff_next;
            level_reg   <= level_next;
        end
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opening_reg <= axtx_pkg::OPENING_FLAGS_RST;
            closing_reg <= axtx_pkg::CLOSING_FLAGS_RST;
            length_reg  <= axtx_pkg::FRAME_LENGTH_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg.payload.index)
                axtx_pkg::CFG_OPENING_FLAGS: opening_reg <= cfg.payload.wdata;
                axtx_pkg::CFG_CLOSING_FLAGS: closing_reg <= cfg.payload.wdata[7:0];
                axtx_pkg::CFG_FRAME_LENGTH:  length_reg  <= cfg.payload.wdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    axtx_frame_buf #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_buf (
        .clk     (clk),
        .wr_en   (buf_wr),
        .wr_addr (buf_wr_addr),
        .wr_data (items.payload.byte_value),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    axtx_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .full      (q_full),
        .pop_valid (results.valid),
        .pop_ready (results.ready),
        .pop_data  (results.payload)
    );

    // a pending stuff bit only follows data or fcs ones
    a_stuff_phase: assert property (@(posedge clk) disable iff (!rst_n)
        stuff_reg |-> ((phase_reg == axtx_pkg::PH_DATA) || (phase_reg == axtx_pkg::PH_FCS)))
        else $error("stuff bit pending outside data or fcs");

    // a run of ones never passes the stuffing length
    a_ones_run: assert property (@(posedge clk) disable iff (!rst_n)
        ones_reg <= axtx_pkg::STUFF_RUN)
        else $error("ones run exceeds stuffing length");

    // idle is only entered on a byte boundary with nothing pending
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == axtx_pkg::PH_IDLE) |-> ((bit_pos_reg == 3'd0) && !stuff_reg))
        else $error("idle with a partial byte or a pending stuff bit");

    // the frame done result leaves the transmitter idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.frame_done) |=> (phase_reg == axtx_pkg::PH_IDLE))
        else $error("frame done without returning to idle");

    // fcs phase never counts past its two bytes
    a_fcs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == axtx_pkg::PH_FCS) |-> (count_reg <= axtx_pkg::FCS_BYTES))
        else $error("fcs byte count out of range");

endmodule

`default_nettype wire
